// ===== src/imu_fgd_pkg.sv =====
// Shared types and constants for the IMU frame gesture direction unit.
// No dependencies; every other file in src except imu_fgd_fifo imports this package.
package imu_fgd_pkg;

  // Frame layout
  localparam int unsigned FrameLen   = 11;
  localparam int unsigned PosWidth   = 4;
  localparam logic [7:0]  FrameStart = 8'h55;
  localparam logic [7:0]  FrameAccel = 8'h51;

  // Configuration
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned ThrWidth    = 16;
  localparam logic [ThrWidth-1:0] ThrReset = 16'd4096;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_X_THR = 2'd0,
    REG_Y_THR = 2'd1,
    REG_Z_THR = 2'd2
  } reg_idx_e;

  // Direction codes as seen on the result port
  typedef enum logic [2:0] {
    DIR_NONE = 3'd0,
    DIR_XP   = 3'd1,
    DIR_YP   = 3'd2,
    DIR_ZP   = 3'd3,
    DIR_XN   = 3'd4,
    DIR_YN   = 3'd5,
    DIR_ZN   = 3'd6
  } dir_e;

  // Token passed from the deframer to the classifier
  typedef struct packed {
    logic             sess_end;
    logic [2:0][15:0] acc;       // z, y, x sample (x at index 0)
  } token_t;

  // One result beat
  typedef struct packed {
    dir_e direction;
    logic first;
    logic captured;
  } result_t;

endpackage

// ===== src/imu_fgd_fifo.sv =====
// Small synchronous FIFO used for the token queue and the result queue.
// Register-file storage with combinational read at the head pointer; no package use.
module imu_fgd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned AddrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth  = $clog2(Depth + 1);

  logic [Width-1:0]     mem_q [Depth];
  logic [AddrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntWidth'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/imu_fgd_front.sv =====
// Deframer: gathers 11-byte frames, checks start byte, checksum and type,
// and emits sample or session-end tokens. Depends on imu_fgd_pkg.
module imu_fgd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                session_end_i,
  output logic                tok_push_o,
  output imu_fgd_pkg::token_t tok_o
);
  import imu_fgd_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          frame_q [8];   // bytes 0..7 of the current frame
  logic                store;
  logic                last_byte;

  assign last_byte = (pos_q == PosWidth'(FrameLen - 1));

  // Framing state and token generation
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    store      = 1'b0;
    tok_push_o = 1'b0;
    tok_o.sess_end = session_end_i;
    tok_o.acc[0]   = {frame_q[3], frame_q[2]};
    tok_o.acc[1]   = {frame_q[5], frame_q[4]};
    tok_o.acc[2]   = {frame_q[7], frame_q[6]};
    if (accept_i) begin
      if (session_end_i) begin
        tok_push_o = 1'b1;
      end else if (pos_q == '0 && rx_byte_i != FrameStart) begin
        // hunting for a start byte
      end else if (last_byte) begin
        pos_d = '0;
        sum_d = '0;
        tok_push_o = (sum_q == rx_byte_i) && (frame_q[1] == FrameAccel);
      end else begin
        store = (pos_q < PosWidth'(8));
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Frame byte store
  always_ff @(posedge clk_i) begin
    if (store) begin
      frame_q[pos_q[2:0]] <= rx_byte_i;
    end
  end

endmodule

// ===== src/imu_fgd_back.sv =====
// Classifier: holds thresholds, baseline and seen set; turns tokens into results
// over two stages (difference/magnitude, then classify). Depends on imu_fgd_pkg.
module imu_fgd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [imu_fgd_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [imu_fgd_pkg::ThrWidth-1:0] cfg_data_i,
  input  logic                             q_empty_i,
  input  imu_fgd_pkg::token_t              q_tok_i,
  output logic                             q_pop_o,
  input  logic                             out_full_i,
  output logic                             out_push_o,
  output imu_fgd_pkg::result_t             out_res_o
);
  import imu_fgd_pkg::*;

  logic [2:0][ThrWidth-1:0] thr_q;
  logic [2:0][15:0]         base_q, base_d;
  logic                     base_v_q, base_v_d;
  logic [5:0]               seen_q, seen_d;

  // Stage 2 register
  logic                     s2_v_q, s2_v_d;
  logic                     s2_cap_q;
  logic [2:0][15:0]         mag_q, mag_d;
  logic [2:0]               pos_q, pos_d;

  logic                     s2_ready;
  logic                     load_s2;
  logic [2:0]               sig;
  logic [1:0]               axis;
  logic                     pick;
  logic                     gxy, gyx, gxz, gzx, gyz, gzy;
  dir_e                     dir;
  logic [2:0]               seen_idx;
  logic [5:0]               seen_bit;
  logic                     first;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= {3{ThrReset}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_THR: thr_q[0] <= cfg_data_i;
        REG_Y_THR: thr_q[1] <= cfg_data_i;
        REG_Z_THR: thr_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: pop a token, capture baseline or form per-axis change
  assign s2_ready = !s2_v_q || out_push_o;
  assign q_pop_o  = !q_empty_i && s2_ready;
  assign load_s2  = q_pop_o && !q_tok_i.sess_end;

  always_comb begin
    logic [16:0] diff;
    logic [16:0] absd;
    for (int i = 0; i < 3; i++) begin
      diff     = {q_tok_i.acc[i][15], q_tok_i.acc[i]} - {base_q[i][15], base_q[i]};
      absd     = diff[16] ? (17'd0 - diff) : diff;
      mag_d[i] = absd[15:0];
      pos_d[i] = !diff[16] && (diff != '0);
    end
  end

  always_comb begin
    base_d   = base_q;
    base_v_d = base_v_q;
    if (q_pop_o) begin
      if (q_tok_i.sess_end) begin
        base_v_d = 1'b0;
      end else if (!base_v_q) begin
        base_d   = q_tok_i.acc;
        base_v_d = 1'b1;
      end
    end
    s2_v_d = s2_v_q;
    if (load_s2) begin
      s2_v_d = 1'b1;
    end else if (out_push_o) begin
      s2_v_d = 1'b0;
    end
  end

  // Stage 2: significance, dominant axis, sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sig[i] = (mag_q[i] >= thr_q[i]);
    end
    gxy  = mag_q[0] > mag_q[1];
    gyx  = mag_q[1] > mag_q[0];
    gxz  = mag_q[0] > mag_q[2];
    gzx  = mag_q[2] > mag_q[0];
    gyz  = mag_q[1] > mag_q[2];
    gzy  = mag_q[2] > mag_q[1];
    axis = 2'd0;
    pick = 1'b0;
    case (sig)
      3'b001: begin axis = 2'd0; pick = 1'b1; end
      3'b010: begin axis = 2'd1; pick = 1'b1; end
      3'b100: begin axis = 2'd2; pick = 1'b1; end
      3'b011: begin
        if (gxy) begin axis = 2'd0; pick = 1'b1; end
        else if (gyx) begin axis = 2'd1; pick = 1'b1; end
      end
      3'b101: begin
        if (gxz) begin axis = 2'd0; pick = 1'b1; end
        else if (gzx) begin axis = 2'd2; pick = 1'b1; end
      end
      3'b110: begin
        if (gyz) begin axis = 2'd1; pick = 1'b1; end
        else if (gzy) begin axis = 2'd2; pick = 1'b1; end
      end
      3'b111: begin
        if (gxy && gxz) begin axis = 2'd0; pick = 1'b1; end
        else if (gyx && gyz) begin axis = 2'd1; pick = 1'b1; end
        else if (gzx && gzy) begin axis = 2'd2; pick = 1'b1; end
      end
      default: ;
    endcase
    if (!pick) begin
      dir = DIR_NONE;
    end else if (pos_q[axis]) begin
      dir = dir_e'({1'b0, axis} + 3'd1);
    end else begin
      dir = dir_e'({1'b0, axis} + 3'd4);
    end
    seen_idx = 3'(dir) - 3'd1;
    seen_bit = 6'd1 << seen_idx;
    first    = (dir != DIR_NONE) && !(|(seen_q & seen_bit));
  end

  // Result beat
  assign out_push_o = s2_v_q && !out_full_i;
  always_comb begin
    if (s2_cap_q) begin
      out_res_o.direction = DIR_NONE;
      out_res_o.first     = 1'b0;
      out_res_o.captured  = 1'b1;
    end else begin
      out_res_o.direction = dir;
      out_res_o.first     = first;
      out_res_o.captured  = 1'b0;
    end
  end

  // Seen set: session end wins over an update in the same cycle
  always_comb begin
    seen_d = seen_q;
    if (out_push_o && !s2_cap_q && first) begin
      seen_d = seen_q | seen_bit;
    end
    if (q_pop_o && q_tok_i.sess_end) begin
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_v_q <= 1'b0;
      base_q   <= '0;
      seen_q   <= '0;
      s2_v_q   <= 1'b0;
    end else begin
      base_v_q <= base_v_d;
      base_q   <= base_d;
      seen_q   <= seen_d;
      s2_v_q   <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s2) begin
      s2_cap_q <= !base_v_q;
      mag_q    <= mag_d;
      pos_q    <= pos_d;
    end
  end

endmodule

// ===== src/imu_fgd_checker.sv =====
// Port-level checker for imu_frame_gesture_direction_unit, bound to the top level.
// Depends on imu_fgd_pkg.
module imu_fgd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] direction_o,
  input logic       first_occurrence_o,
  input logic       baseline_captured_o
);
  import imu_fgd_pkg::*;

  // A waiting result stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(direction_o) && $stable(first_occurrence_o)
                       && $stable(baseline_captured_o))
    else $error("result payload changed while stalled");

  // Baseline capture carries no direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && baseline_captured_o |-> direction_o == DIR_NONE && !first_occurrence_o)
    else $error("capture beat with a direction");

  // First-occurrence only on a real direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && first_occurrence_o |-> direction_o != DIR_NONE && direction_o <= DIR_ZN)
    else $error("first occurrence flagged without a direction");

endmodule

bind imu_frame_gesture_direction_unit imu_fgd_checker u_imu_fgd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .empty               (empty),
  .pop                 (pop),
  .direction_o         (direction_o),
  .first_occurrence_o  (first_occurrence_o),
  .baseline_captured_o (baseline_captured_o)
);

// ===== src/imu_frame_gesture_direction_unit.sv =====
// Top level of the IMU frame gesture direction unit.
// Depends on imu_fgd_pkg, imu_fgd_front, imu_fgd_fifo and imu_fgd_back.
//
// Usage:
//   Input channel: one serial byte (rx_byte_i) or a session-end marker
//   (session_end_i) per beat; a beat is taken when push is high and full low.
//   Result channel: one beat per good acceleration frame; the head result is on
//   direction_o / first_occurrence_o / baseline_captured_o while empty is low
//   and is taken when pop is high.
//   Config: cfg_we_i writes cfg_data_i into threshold cfg_idx_i (0 x, 1 y, 2 z);
//   write only while the block is idle.
// Throughput: one input beat per cycle while full is low. The deframer consumes a byte per
// cycle and the classifier takes one token per cycle through its two stages while the result queue has room.
// Result path: the frame's token is written into the token queue when its checksum byte
// is taken, then popped into the stage 2 register, then written into the result queue.
// Reset: framing, baseline, seen set and both queues clear; thresholds go to 4096.
// Stall: when pop is held low the result queue fills, the classifier stops, the
// token queue fills and full rises; nothing is dropped.
module imu_frame_gesture_direction_unit #(
  parameter int unsigned QueueDepth  = 2,
  parameter int unsigned ResultDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [imu_fgd_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [imu_fgd_pkg::ThrWidth-1:0]    cfg_data_i,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          rx_byte_i,
  input  logic                                session_end_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [2:0]                          direction_o,
  output logic                                first_occurrence_o,
  output logic                                baseline_captured_o
);
  import imu_fgd_pkg::*;

  localparam int unsigned TokWidth = $bits(token_t);
  localparam int unsigned ResWidth = $bits(result_t);

  logic    accept;
  logic    tok_push;
  token_t  tok_in, tok_out;
  logic    q_full, q_empty, q_pop;
  logic    out_push, out_full;
  result_t res_in, res_out;

  assign accept = push && !full;
  assign full   = q_full;

  imu_fgd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .session_end_i (session_end_i),
    .tok_push_o    (tok_push),
    .tok_o         (tok_in)
  );

  // Token queue between deframer and classifier
  imu_fgd_fifo #(
    .Width (TokWidth),
    .Depth (QueueDepth)
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .pop_i   (q_pop),
    .data_o  (tok_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  imu_fgd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_tok_i    (tok_out),
    .q_pop_o    (q_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_res_o  (res_in)
  );

  // Result queue toward the consumer
  imu_fgd_fifo #(
    .Width (ResWidth),
    .Depth (ResultDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign direction_o         = res_out.direction;
  assign first_occurrence_o  = res_out.first;
  assign baseline_captured_o = res_out.captured;

endmodule
